>>> rtl/core/bfsp_pkg.sv
// Shared constants, codes and control structs for the best-fit shelf packer.
// No dependencies; bfsp_ctrl, bfsp_datapath and best_fit_shelf_packer refer to this package.
`default_nettype none

package bfsp_pkg;

   localparam int MAX_SHELVES_DEFAULT = 64;

   localparam int DIM_W         = 16;
   localparam int LEN_W         = 16;
   localparam int LIMIT_W       = 22;
   localparam int TOTAL_W       = 22;
   localparam int STATUS_W      = 2;
   localparam int SHELF_INDEX_W = 6;
   localparam int DIV_CNT_W     = 4;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 64;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [LEN_W-1:0]   RESET_LENGTH = 16'd1024;
   localparam logic [LIMIT_W-1:0] RESET_LIMIT  = 22'd768;
   localparam logic [TOTAL_W-1:0] SUM_MAX      = 22'h3F_FFFF;

   localparam logic CMD_PLACE = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_PLACED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CLEARED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

   // register select, taken from paddr bit 2
   localparam logic REG_SHELF_LENGTH = 1'b0;
   localparam logic REG_HEIGHT_LIMIT = 1'b1;

   typedef struct packed {
      logic load_req;
      logic init_write;
      logic clear_write;
      logic mul;
      logic div_step;
      logic scan_issue;
      logic update;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic need_scale;
      logic div_last;
      logic scan_last;
   } dp_stat_type;

endpackage

`default_nettype wire

>>> rtl/core/bfsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bfsp_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/bfsp_ctrl.sv
// Sequencer for the shelf packer: request intake, scale, scan, update or clear, result.
// Depends on bfsp_pkg; drives bfsp_datapath through dp_cmd_type.
`default_nettype none

module bfsp_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic                 req_cmd,
   output      logic                 req_tready,
   input  wire logic                 rsp_tready,
   output      logic                 rsp_tvalid,
   input  wire bfsp_pkg::dp_stat_type stat,
   output      bfsp_pkg::dp_cmd_type  cmd
);

   localparam logic [3:0] ST_INIT   = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_MUL    = 4'd2;
   localparam logic [3:0] ST_DIV    = 4'd3;
   localparam logic [3:0] ST_SCAN   = 4'd4;
   localparam logic [3:0] ST_DRAIN  = 4'd5;
   localparam logic [3:0] ST_UPDATE = 4'd6;
   localparam logic [3:0] ST_CLEAR  = 4'd7;
   localparam logic [3:0] ST_OUT    = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.init_write = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = (req_cmd == bfsp_pkg::CMD_CLEAR) ? ST_CLEAR : ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = stat.need_scale ? ST_DIV : ST_SCAN;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_OUT;
         end
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            state_in        = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> rtl/core/bfsp_datapath.sv
// Datapath: scaling multiply and serial divide, shelf RAMs, best-fit scan,
// shelf update, height total and result registers. Depends on bfsp_pkg, bfsp_ram.
`default_nettype none

module bfsp_datapath #(
   parameter int MAX_SHELVES = bfsp_pkg::MAX_SHELVES_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire bfsp_pkg::dp_cmd_type                 cmd,
   output      bfsp_pkg::dp_stat_type                stat,
   input  wire logic [bfsp_pkg::DIM_W-1:0]           req_width,
   input  wire logic [bfsp_pkg::DIM_W-1:0]           req_height,
   input  wire logic [bfsp_pkg::LEN_W-1:0]           shelf_length,
   input  wire logic [bfsp_pkg::LIMIT_W-1:0]         height_limit,
   output      logic [bfsp_pkg::STATUS_W-1:0]        status,
   output      logic [bfsp_pkg::SHELF_INDEX_W-1:0]   shelf_index,
   output      logic [bfsp_pkg::DIM_W-1:0]           placed_width,
   output      logic [bfsp_pkg::DIM_W-1:0]           placed_height,
   output      logic [bfsp_pkg::TOTAL_W-1:0]         total_height,
   output      logic                                 over_limit
);

   localparam int IDX_W    = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
   localparam int OPEN_W   = $clog2(MAX_SHELVES + 1);
   localparam int SUM_RAW  = bfsp_pkg::DIM_W + $clog2(MAX_SHELVES + 1);
   localparam int SUM_W    = (SUM_RAW > bfsp_pkg::TOTAL_W) ? SUM_RAW : bfsp_pkg::TOTAL_W;
   localparam int DW       = bfsp_pkg::DIM_W;
   localparam int ACC_W    = 2 * DW + 1;

   logic [DW-1:0]      w_ff, h_ff, place_w_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [bfsp_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic [IDX_W-1:0]   scan_idx_ff, pend_idx_ff, best_idx_ff;
   logic               pend_valid_ff, found_ff;
   logic [DW-1:0]      best_left_ff, best_height_ff;
   logic [OPEN_W-1:0]  open_ff;
   logic [SUM_W-1:0]   sum_ff;

   logic [bfsp_pkg::STATUS_W-1:0]      res_status_ff;
   logic [bfsp_pkg::SHELF_INDEX_W-1:0] res_idx_ff;
   logic [DW-1:0]                      res_w_ff, res_h_ff;
   logic [bfsp_pkg::TOTAL_W-1:0]       res_total_ff;
   logic                               res_over_ff;

   logic [DW-1:0]      room_rd, height_rd;
   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [DW-1:0]      room_wdata, height_wdata;

   // divider step
   logic [DW:0]        rem_sh, rem_next;
   logic               q_bit;
   logic [ACC_W-1:0]   acc_step;

   // scan compare
   logic               fits, take;
   logic [DW-1:0]      left;

   // update
   logic               open_full, upd_place;
   logic [IDX_W-1:0]   upd_idx;
   logic [DW-1:0]      upd_room, old_h, new_h;
   logic [SUM_W-1:0]   sum_upd, sum_view;
   logic [bfsp_pkg::TOTAL_W-1:0] total_sat;

   bfsp_ram #(.WIDTH(DW), .DEPTH(MAX_SHELVES), .ADDR_W(IDX_W)) u_room_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (room_wdata),
      .rd_en   (cmd.scan_issue),
      .rd_addr (scan_idx_ff),
      .rd_data (room_rd)
   );

   bfsp_ram #(.WIDTH(DW), .DEPTH(MAX_SHELVES), .ADDR_W(IDX_W)) u_height_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (height_wdata),
      .rd_en   (cmd.scan_issue),
      .rd_addr (scan_idx_ff),
      .rd_data (height_rd)
   );

   // restoring division, one quotient bit per step
   always_comb begin
      rem_sh   = {acc_ff[2*DW-1:DW], acc_ff[DW-1]};
      q_bit    = (rem_sh >= {1'b0, w_ff});
      rem_next = q_bit ? (rem_sh - {1'b0, w_ff}) : rem_sh;
      acc_step = {rem_next, acc_ff[DW-2:0], q_bit};
   end

   always_comb begin
      fits = (room_rd > place_w_ff);
      left = room_rd - place_w_ff;
      take = pend_valid_ff && fits && (!found_ff || (left < best_left_ff));
   end

   always_comb begin
      open_full = (open_ff == OPEN_W'(MAX_SHELVES));
      upd_place = found_ff || !open_full;
      upd_idx   = found_ff ? best_idx_ff : IDX_W'(open_ff);
      upd_room  = found_ff ? best_left_ff : (shelf_length - place_w_ff);
      old_h     = found_ff ? best_height_ff : '0;
      new_h     = (h_ff > old_h) ? h_ff : old_h;
      sum_upd   = sum_ff + SUM_W'(new_h) - SUM_W'(old_h);
      sum_view  = upd_place ? sum_upd : sum_ff;
      total_sat = (sum_view > SUM_W'(bfsp_pkg::SUM_MAX)) ? bfsp_pkg::SUM_MAX
                                                          : sum_view[bfsp_pkg::TOTAL_W-1:0];
   end

   always_comb begin
      ram_we       = 1'b0;
      ram_waddr    = '0;
      room_wdata   = upd_room;
      height_wdata = new_h;
      if (cmd.init_write) begin
         ram_we       = 1'b1;
         room_wdata   = bfsp_pkg::RESET_LENGTH;
         height_wdata = '0;
      end else if (cmd.clear_write) begin
         ram_we       = 1'b1;
         room_wdata   = shelf_length;
         height_wdata = '0;
      end else if (cmd.update) begin
         ram_we    = upd_place;
         ram_waddr = upd_idx;
      end
   end

   always_comb begin
      stat.need_scale = (w_ff > shelf_length);
      stat.div_last   = (div_cnt_ff == bfsp_pkg::DIV_CNT_W'(DW - 1));
      stat.scan_last  = ((OPEN_W'(scan_idx_ff) + OPEN_W'(1)) == open_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff       <= OPEN_W'(1);
         sum_ff        <= '0;
         found_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= cmd.scan_issue;
         if (cmd.load_req) begin
            found_ff <= 1'b0;
         end else if (take) begin
            found_ff <= 1'b1;
         end
         if (cmd.clear_write) begin
            open_ff <= OPEN_W'(1);
            sum_ff  <= '0;
         end else if (cmd.update && upd_place) begin
            sum_ff <= sum_upd;
            if (!found_ff) begin
               open_ff <= open_ff + OPEN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         w_ff        <= req_width;
         h_ff        <= req_height;
         scan_idx_ff <= '0;
      end
      if (cmd.mul) begin
         acc_ff     <= ACC_W'(shelf_length) * ACC_W'(h_ff);
         div_cnt_ff <= '0;
         place_w_ff <= stat.need_scale ? shelf_length : w_ff;
      end
      if (cmd.div_step) begin
         acc_ff     <= acc_step;
         div_cnt_ff <= div_cnt_ff + bfsp_pkg::DIV_CNT_W'(1);
         if (stat.div_last) begin
            h_ff <= acc_step[DW-1:0];
         end
      end
      if (cmd.scan_issue) begin
         scan_idx_ff <= scan_idx_ff + IDX_W'(1);
         pend_idx_ff <= scan_idx_ff;
      end
      if (take) begin
         best_idx_ff    <= pend_idx_ff;
         best_left_ff   <= left;
         best_height_ff <= height_rd;
      end
      if (cmd.clear_write) begin
         res_status_ff <= bfsp_pkg::STATUS_CLEARED;
         res_idx_ff    <= '0;
         res_w_ff      <= '0;
         res_h_ff      <= '0;
         res_total_ff  <= '0;
         res_over_ff   <= 1'b0;
      end else if (cmd.update) begin
         res_status_ff <= upd_place ? bfsp_pkg::STATUS_PLACED : bfsp_pkg::STATUS_DROPPED;
         res_idx_ff    <= upd_place ? bfsp_pkg::SHELF_INDEX_W'(upd_idx) : '0;
         res_w_ff      <= place_w_ff;
         res_h_ff      <= h_ff;
         res_total_ff  <= total_sat;
         res_over_ff   <= (total_sat > height_limit);
      end
      if (cmd.load_out) begin
         status        <= res_status_ff;
         shelf_index   <= res_idx_ff;
         placed_width  <= res_w_ff;
         placed_height <= res_h_ff;
         total_height  <= res_total_ff;
         over_limit    <= res_over_ff;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/best_fit_shelf_packer.sv
// Top level of the best-fit shelf packer: stream ports, register port,
// controller and datapath. Depends on bfsp_pkg, bfsp_ctrl, bfsp_datapath.
//
// Usage:
//   req_* carries one request: place a rectangle (tuser = 0) or clear all
//   shelves (tuser = 1). rsp_* returns exactly one result per request, in order.
//   csr_* holds shelf_length (0x0) and height_limit (0x4); write only while idle.
// Sequence from accept to rsp_tvalid, N = open shelves:
//   place, no scaling : multiply, scan of N shelves, drain, update, output
//   place, scaled     : multiply, 16-step serial divide, scan, drain, update, output
//   clear             : clear of all shelves, output
// One request is in flight at a time; the shelf scan reads one RAM entry per
// cycle, so the scan sets the rate.
// Reset: req_tready stays low for one cycle while shelf 0 is written; open
// shelves = 1, total height = 0, registers return to 1024 and 768.
// Stall: a result waits in the output register while rsp_tready is low; the
// next request is still accepted and processed, then holds until the register
// empties.
`default_nettype none

module best_fit_shelf_packer #(
   parameter int MAX_SHELVES = bfsp_pkg::MAX_SHELVES_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   input  wire logic [bfsp_pkg::REQ_DATA_W-1:0]    req_tdata,  // rect_width, rect_height
   input  wire logic                               req_tuser,  // cmd
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // shelf_index, placed_width, placed_height, total_height, over_limit, zero pad
   output      logic [bfsp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output      logic [bfsp_pkg::STATUS_W-1:0]      rsp_tuser,  // status
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [bfsp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [bfsp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output      logic [bfsp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output      logic                               csr_pready
);

   logic [bfsp_pkg::LEN_W-1:0]   length_ff;
   logic [bfsp_pkg::LIMIT_W-1:0] limit_ff;
   logic                         csr_write;

   bfsp_pkg::dp_cmd_type  cmd;
   bfsp_pkg::dp_stat_type stat;

   logic [bfsp_pkg::SHELF_INDEX_W-1:0] shelf_index;
   logic [bfsp_pkg::DIM_W-1:0]         placed_width, placed_height;
   logic [bfsp_pkg::TOTAL_W-1:0]       total_height;
   logic                               over_limit;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= bfsp_pkg::RESET_LENGTH;
         limit_ff  <= bfsp_pkg::RESET_LIMIT;
      end else if (csr_write) begin
         if (csr_paddr[2] == bfsp_pkg::REG_SHELF_LENGTH) begin
            length_ff <= csr_pwdata[bfsp_pkg::LEN_W-1:0];
         end else begin
            limit_ff <= csr_pwdata[bfsp_pkg::LIMIT_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == bfsp_pkg::REG_HEIGHT_LIMIT)
                     ? bfsp_pkg::CSR_DATA_W'(limit_ff)
                     : bfsp_pkg::CSR_DATA_W'(length_ff);

   bfsp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_tuser),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .stat       (stat),
      .cmd        (cmd)
   );

   bfsp_datapath #(.MAX_SHELVES(MAX_SHELVES)) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_width     (req_tdata[15:0]),
      .req_height    (req_tdata[31:16]),
      .shelf_length  (length_ff),
      .height_limit  (limit_ff),
      .status        (rsp_tuser),
      .shelf_index   (shelf_index),
      .placed_width  (placed_width),
      .placed_height (placed_height),
      .total_height  (total_height),
      .over_limit    (over_limit)
   );

   assign rsp_tdata = {3'b000, over_limit, total_height, placed_height, placed_width,
                       shelf_index};

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while previous one still in progress");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == bfsp_pkg::STATUS_CLEARED)) |-> (rsp_tdata == '0))
      else $error("clear result carries nonzero payload");

   a_drop_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == bfsp_pkg::STATUS_DROPPED)) |-> (shelf_index == '0))
      else $error("dropped result carries a shelf index");

endmodule

`default_nettype wire
